/* rtl/assert_macros.svh */
// Assertion macros for the Intel HEX loader RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ihex_pkg.sv */
// Shared types and constants of the Intel HEX record loader.
// No dependencies; imported by every module of the block.
package ihex_pkg;

  localparam int DEFAULT_IMAGE_DEPTH = 2048;
  localparam logic [11:0] IMAGE_LENGTH_RESET = 12'd2048;
  localparam logic [9:0] POS_MAX = 10'd1023;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_FF    = 8'hFF;

  typedef enum logic [1:0] {
    CMD_FEED  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_BUSY      = 3'd0,
    STAT_STORED    = 3'd1,
    STAT_IGNORED   = 3'd2,
    STAT_SKIPPED   = 3'd3,
    STAT_FIELD_ERR = 3'd4,
    STAT_CSUM_ERR  = 3'd5,
    STAT_HALTED    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_SKIP   = 2'd2
  } line_mode_t;

  typedef enum logic [2:0] {
    F_NONE  = 3'd0,
    F_COUNT = 3'd1,
    F_ADDR  = 3'd2,
    F_KIND  = 3'd3,
    F_PAIR  = 3'd4
  } field_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FEED,
    ST_FILL,
    ST_HDR,
    ST_CHECK,
    ST_COPY,
    ST_READ,
    ST_READ_DATA,
    ST_EMIT
  } state_t;

  // Classification of one record character.
  typedef struct packed {
    logic       is_hex;
    logic [3:0] digit;
    field_t     field;
    logic [8:0] pair_k;
    logic       pair_odd;
    logic       pair_data;
  } ihex_dec_t;

endpackage

/* rtl/ihex_field_decode.sv */
// Character classifier: hex digit value and record field for a line position.
// Depends on ihex_pkg.
module ihex_field_decode import ihex_pkg::*; (
  input  logic [7:0] char_code,
  input  logic [9:0] line_position,
  input  logic [7:0] record_count,
  output ihex_dec_t  dec
);

  logic [9:0] pair_q;
  logic [8:0] pair_k;

  assign pair_q = line_position - 10'd9;
  assign pair_k = pair_q[9:1];

  always_comb begin
    dec = '0;
    // hex digit value
    if (char_code inside {[8'h30:8'h39]}) begin
      dec.is_hex = 1'b1;
      dec.digit  = char_code[3:0];
    end else if (char_code inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      dec.is_hex = 1'b1;
      dec.digit  = char_code[3:0] + 4'd9;
    end
    // field by position
    dec.pair_k    = pair_k;
    dec.pair_odd  = pair_q[0];
    dec.pair_data = (pair_k < {1'b0, record_count});
    if (line_position <= 10'd2) begin
      dec.field = F_COUNT;
    end else if (line_position <= 10'd6) begin
      dec.field = F_ADDR;
    end else if (line_position <= 10'd8) begin
      dec.field = F_KIND;
    end else if (pair_k <= {1'b0, record_count}) begin
      dec.field = F_PAIR;
    end else begin
      dec.field = F_NONE;
    end
  end

endmodule

/* rtl/intel_hex_record_loader_core.sv */
// Intel HEX record loader: sequencer, record buffer, image store, result register.
// Depends on ihex_pkg, ihex_field_decode and assert_macros.svh.
//
// Usage:
//   Input beats on s_* carry one command: tuser is the command (feed character,
//   read image byte, clear image and error), tdata the character and read address.
//   Each beat gives exactly one result beat on m_*: a status code and a read byte.
//   The image_length register is to be written on cfg_* only while the block is
//   idle; the block itself does not enforce this. One beat is worked on at a time
//   and s_tready is low meanwhile. Plain character or carriage return: FEED, EMIT.
//   Image read: READ, READ_DATA, EMIT (registered image store read port).
//   Line end of a record: FEED, FILL, HDR, CHECK, COPY (when stored), EMIT;
//   the record buffer is padded one byte a cycle, the four header bytes go through
//   the shared 8-bit checksum subtractor one a cycle, and the copy into the image
//   store moves one byte a cycle over its single write port.
//   Clear command: CLEAR, EMIT; one image entry zeroed per cycle.
// Reset: a clearing pass zeroes the image store; s_tready
//   stays low during it, configuration writes are still taken.
// Stall: the result waits in the output register; the next beat is accepted
//   meanwhile and its result is held until the register is free.
module intel_hex_record_loader_core import ihex_pkg::*; #(
  parameter int IMAGE_DEPTH = DEFAULT_IMAGE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] read_address, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] status, [10:3] read_data, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data   // [11:0] image_length
);

`include "assert_macros.svh"

  localparam int AW = $clog2(IMAGE_DEPTH);
  localparam logic [16:0] DEPTH_EXT = 17'(IMAGE_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(IMAGE_DEPTH - 1);

  state_t state, state_next;

  // configuration
  logic [11:0] image_length;

  // latched beat
  cmd_t        it_cmd;
  logic [7:0]  it_char;
  logic [10:0] it_raddr;

  // line and record state
  logic        halted;
  logic [9:0]  line_position;
  line_mode_t  line_mode;
  logic [3:0]  upper_nibble;
  logic        pair_bad;
  logic [7:0]  record_count;
  logic [15:0] record_address;
  logic [7:0]  record_kind;
  logic        header_bad;
  logic [7:0]  running_sum;
  logic [7:0]  checksum_field;

  // sequencer counters
  logic [8:0]    idx;
  logic [8:0]    fill_full;
  logic          fill_part;
  logic [1:0]    hdr_step;
  logic [AW-1:0] clr_addr;
  logic          clr_emit;
  logic          pend;
  logic [AW-1:0] pend_addr;

  // result
  status_t    res_status;
  logic [7:0] res_data;

  // memories and their ports
  logic [7:0]    rec_buf [256];
  logic [7:0]    buf_q;
  logic          buf_we;
  logic          buf_re;
  logic [7:0]    buf_waddr;
  logic [7:0]    buf_wdata;
  logic [7:0]    img [IMAGE_DEPTH];
  logic [7:0]    img_q;
  logic          img_we;
  logic          img_re;
  logic [AW-1:0] img_waddr;
  logic [7:0]    img_wdata;

  // combinational helpers
  ihex_dec_t   dec;
  logic        accept;
  logic        out_free;
  logic [7:0]  sub_b;
  logic [7:0]  sub_out;
  logic [7:0]  feed_v;
  logic [7:0]  fill_v;
  logic [7:0]  part_v;
  logic        feed_pair_wr;
  logic        is_text;
  logic        hdr_fail;
  logic        fill_more;
  logic        copy_more;
  logic [9:0]  tail_len;
  logic [16:0] limit;
  logic [16:0] copy_end;
  logic        fits;
  logic [16:0] rd_ext;
  logic        rd_in_range;
  logic [16:0] pend_ext;
  logic [16:0] copy_addr;

  ihex_field_decode u_decode (
    .char_code    (it_char),
    .line_position(line_position),
    .record_count (record_count),
    .dec          (dec)
  );

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // shared checksum subtractor
  assign sub_out = running_sum - sub_b;

  // per-character and per-record decisions
  assign is_text      = (it_char != CHAR_CR) && (it_char != CHAR_LF);
  assign feed_v       = (pair_bad || !dec.is_hex) ? BYTE_FF : {upper_nibble, dec.digit};
  assign feed_pair_wr = is_text && (line_mode == MODE_RECORD) && (dec.field == F_PAIR) &&
                        dec.pair_odd && dec.pair_data;
  assign hdr_fail     = (line_position <= 10'd7) || header_bad;
  assign tail_len     = (line_position > 10'd9) ? (line_position - 10'd9) : 10'd0;
  assign part_v       = pair_bad ? BYTE_FF : {4'd0, upper_nibble};
  assign fill_v       = ((idx == fill_full) && fill_part) ? part_v : BYTE_FF;
  assign fill_more    = (idx < {1'b0, record_count});
  assign copy_more    = (idx < {1'b0, record_count});
  assign limit        = ({5'd0, image_length} < DEPTH_EXT) ? {5'd0, image_length} : DEPTH_EXT;
  assign copy_end     = {1'b0, record_address} + {9'd0, record_count};
  assign fits         = (copy_end <= limit);
  assign copy_addr    = {1'b0, record_address} + {8'd0, idx};
  assign rd_ext       = {6'd0, it_raddr};
  assign rd_in_range  = (rd_ext < DEPTH_EXT);
  assign pend_ext     = 17'(pend_addr);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == CLR_LAST) state_next = clr_emit ? ST_EMIT : ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(s_tuser))
            CMD_FEED:  state_next = halted ? ST_EMIT : ST_FEED;
            CMD_READ:  state_next = ST_READ;
            CMD_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_EMIT;
          endcase
        end
      end
      ST_FEED: begin
        if ((it_char == CHAR_LF) && (line_mode == MODE_RECORD) && !hdr_fail) begin
          state_next = ST_FILL;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_FILL: begin
        if (!fill_more) state_next = ST_HDR;
      end
      ST_HDR: begin
        if (hdr_step == 2'd3) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if ((running_sum == checksum_field) && (record_kind == BYTE_ZERO) && fits) begin
          state_next = ST_COPY;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_COPY: begin
        if (!copy_more && !pend) state_next = ST_EMIT;
      end
      ST_READ:      state_next = ST_READ_DATA;
      ST_READ_DATA: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory ports, subtractor operand, handshake
  always_comb begin
    s_tready  = (state == ST_IDLE);
    sub_b     = BYTE_ZERO;
    buf_we    = 1'b0;
    buf_re    = 1'b0;
    buf_waddr = idx[7:0];
    buf_wdata = fill_v;
    img_we    = 1'b0;
    img_re    = 1'b0;
    img_waddr = pend_addr;
    img_wdata = buf_q;
    case (state)
      ST_FEED: begin
        sub_b     = feed_v;
        buf_we    = feed_pair_wr;
        buf_waddr = dec.pair_k[7:0];
        buf_wdata = feed_v;
      end
      ST_FILL: begin
        sub_b  = fill_v;
        buf_we = fill_more;
      end
      ST_HDR: begin
        case (hdr_step)
          2'd0:    sub_b = record_count;
          2'd1:    sub_b = record_kind;
          2'd2:    sub_b = record_address[7:0];
          default: sub_b = record_address[15:8];
        endcase
      end
      ST_COPY: begin
        buf_re = copy_more;
        img_we = pend;
      end
      ST_CLEAR: begin
        img_we    = 1'b1;
        img_waddr = clr_addr;
        img_wdata = BYTE_ZERO;
      end
      ST_READ: begin
        img_re = 1'b1;
      end
      default: begin
        s_tready = (state == ST_IDLE);
      end
    endcase
  end

  // record buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (buf_we) rec_buf[buf_waddr] <= buf_wdata;
    if (buf_re) buf_q <= rec_buf[idx[7:0]];
  end

  // image store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (img_we) img[img_waddr] <= img_wdata;
    if (img_re) img_q <= img[rd_ext[AW-1:0]];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= IMAGE_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      image_length <= cfg_data;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      halted         <= 1'b0;
      line_position  <= 10'd0;
      line_mode      <= MODE_START;
      upper_nibble   <= 4'd0;
      pair_bad       <= 1'b0;
      record_count   <= 8'd0;
      record_address <= 16'd0;
      record_kind    <= 8'd0;
      header_bad     <= 1'b0;
      running_sum    <= 8'd0;
      checksum_field <= BYTE_FF;
      clr_addr       <= '0;
      clr_emit       <= 1'b0;
      pend           <= 1'b0;
      idx            <= 9'd0;
      hdr_step       <= 2'd0;
    end else begin
      case (state)
        // zero one image entry a cycle, then drop the line state and error
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLR_LAST) begin
            clr_addr       <= '0;
            halted         <= 1'b0;
            line_position  <= 10'd0;
            line_mode      <= MODE_START;
            upper_nibble   <= 4'd0;
            pair_bad       <= 1'b0;
            record_count   <= 8'd0;
            record_address <= 16'd0;
            record_kind    <= 8'd0;
            header_bad     <= 1'b0;
            running_sum    <= 8'd0;
            checksum_field <= BYTE_FF;
          end
        end

        // latch the beat and preset the result
        ST_IDLE: begin
          if (accept) begin
            it_cmd   <= cmd_t'(s_tuser);
            it_char  <= s_tdata[7:0];
            it_raddr <= s_tdata[18:8];
            res_data <= BYTE_ZERO;
            clr_emit <= 1'b1;
            case (cmd_t'(s_tuser))
              CMD_FEED: res_status <= halted ? STAT_HALTED : STAT_BUSY;
              CMD_READ: res_status <= halted ? STAT_HALTED : STAT_BUSY;
              default:  res_status <= STAT_BUSY;
            endcase
          end
        end

        // one text character
        ST_FEED: begin
          if (it_char == CHAR_CR) begin
            res_status <= STAT_BUSY;
          end else if (it_char == CHAR_LF) begin
            line_mode     <= MODE_START;
            line_position <= 10'd0;
            if (line_mode == MODE_RECORD) begin
              if (hdr_fail) begin
                halted     <= 1'b1;
                res_status <= STAT_FIELD_ERR;
              end else begin
                idx       <= tail_len[9:1];
                fill_full <= tail_len[9:1];
                fill_part <= tail_len[0];
                if ((tail_len[9:1] == {1'b0, record_count}) && tail_len[0]) begin
                  checksum_field <= part_v;
                end
              end
            end else begin
              res_status <= STAT_SKIPPED;
            end
          end else if (line_mode == MODE_START) begin
            res_status <= STAT_BUSY;
            if (it_char == CHAR_COLON) begin
              line_mode      <= MODE_RECORD;
              line_position  <= 10'd1;
              header_bad     <= 1'b0;
              record_count   <= 8'd0;
              record_address <= 16'd0;
              record_kind    <= 8'd0;
              running_sum    <= 8'd0;
              checksum_field <= BYTE_FF;
              pair_bad       <= 1'b0;
              upper_nibble   <= 4'd0;
            end else begin
              line_mode <= MODE_SKIP;
            end
          end else if (line_mode == MODE_RECORD) begin
            res_status <= STAT_BUSY;
            case (dec.field)
              F_COUNT: begin
                if (!dec.is_hex) header_bad <= 1'b1;
                else             record_count <= {record_count[3:0], dec.digit};
              end
              F_ADDR: begin
                if (!dec.is_hex) header_bad <= 1'b1;
                else             record_address <= {record_address[11:0], dec.digit};
              end
              F_KIND: begin
                if (!dec.is_hex) header_bad <= 1'b1;
                else             record_kind <= {record_kind[3:0], dec.digit};
              end
              F_PAIR: begin
                if (!dec.pair_odd) begin
                  pair_bad     <= !dec.is_hex;
                  upper_nibble <= dec.is_hex ? dec.digit : 4'd0;
                end else if (dec.pair_data) begin
                  running_sum <= sub_out;
                end else begin
                  checksum_field <= feed_v;
                end
              end
              default: begin
                header_bad <= header_bad;
              end
            endcase
            if (line_position < POS_MAX) line_position <= line_position + 10'd1;
          end else begin
            res_status <= STAT_BUSY;
          end
        end

        // pad the missing data pairs
        ST_FILL: begin
          hdr_step <= 2'd0;
          if (fill_more) begin
            running_sum <= sub_out;
            idx         <= idx + 9'd1;
          end
        end

        // take count, type and address bytes off the sum
        ST_HDR: begin
          running_sum <= sub_out;
          hdr_step    <= hdr_step + 2'd1;
        end

        // verify the checksum and decide on the copy
        ST_CHECK: begin
          idx  <= 9'd0;
          pend <= 1'b0;
          if (running_sum != checksum_field) begin
            halted     <= 1'b1;
            res_status <= STAT_CSUM_ERR;
          end else if ((record_kind == BYTE_ZERO) && fits) begin
            res_status <= STAT_STORED;
          end else begin
            res_status <= STAT_IGNORED;
          end
        end

        // read buffer entry, write it in the following cycle
        ST_COPY: begin
          pend      <= copy_more;
          pend_addr <= copy_addr[AW-1:0];
          if (copy_more) idx <= idx + 9'd1;
        end

        ST_READ_DATA: begin
          res_data <= rd_in_range ? img_q : BYTE_ZERO;
        end

        default: begin
          pend <= pend;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if ((state == ST_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'd0, res_data, res_status};
      end
    end
  end

  // checks
  `ASSERT_IMPL(a_img_write_src, img_we, (state == ST_CLEAR) || (state == ST_COPY), "image write outside clear or copy")
  `ASSERT_IMPL(a_copy_in_limit, (state == ST_COPY) && pend, pend_ext < limit, "copy beyond usable length")
  `ASSERT_NEXT(a_halted_feed, accept && (s_tuser == CMD_FEED) && halted, state == ST_EMIT, "halted feed went to work")
  `ASSERT_IMPL(a_halt_cause, $rose(halted), (res_status == STAT_FIELD_ERR) || (res_status == STAT_CSUM_ERR), "halt without error status")

endmodule
